// ----- rtl/core/count_vector_rescaler_defines.svh -----
// assertion macros used by the rescaler port-level checker
`ifndef COUNT_VECTOR_RESCALER_DEFINES_SVH
`define COUNT_VECTOR_RESCALER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CVR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cvr check failed");

// next-cycle implication, sampled on clk, off during reset
`define CVR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cvr check failed");

`endif

// ----- rtl/core/cvr_pkg.sv -----
// shared types and constants of the count vector rescaler
`default_nettype none

package cvr_pkg;

  localparam int COUNT_BITS    = 20;
  localparam int NUM_COUNTS    = 6;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;

  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DEPTH_GOAL      = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SKIP_WHEN_BELOW = cfg_idx_t'(1);

  typedef struct packed {
    count_t count_a;
    count_t count_c;
    count_t count_g;
    count_t count_t;
    count_t count_n;
    count_t count_del;
  } in_t;

  typedef struct packed {
    count_t scaled_a;
    count_t scaled_c;
    count_t scaled_g;
    count_t scaled_t;
    count_t scaled_n;
    count_t scaled_del;
    logic   passed_through;
    logic   zero_total_error;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/core/count_vector_rescaler.sv -----
// count vector rescaler: six counts scaled to a target depth by largest remainder
//
//   channel | ports                            | handshake
//   --------+----------------------------------+------------------------------
//   input   | start, busy, in_data             | taken when start & !busy
//   result  | out_valid, out_data              | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_index, | written when cfg_valid &
//           | cfg_wdata                        | cfg_ready, ready always high
//
// pass-through and zero-total items finish in DECIDE, after the SUM state
// scaled items go through MULDIV, REMC and DONE, with SHINIT and then SCAN
// once per leftover unit (at most 5 units) when there is leftover; the bit-serial
// multiplier and restoring divider run in lockstep, one quotient per
// count, then the scan
// one item at a time: busy stays high until the result strobe
// synchronous active-low reset: depth goal 0, skip_when_below 1, idle
`default_nettype none

module count_vector_rescaler import cvr_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire in_t                      in_data,
  output logic                          out_valid,
  output out_t                          out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire cfg_idx_t                 cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int CB     = COUNT_BITS;
  localparam int NC     = NUM_COUNTS;
  localparam int TOT_W  = CB + 3;
  localparam int SH_W   = CB + 6;
  localparam int STEP_W = $clog2(CB);
  localparam int IDX_W  = $clog2(NC);
  localparam int PH_W   = $clog2(NC + 1);
  localparam int UNIT_W = 3;
  localparam int MAX_REM = 5;

  typedef logic [TOT_W-1:0]        total_t;
  typedef logic signed [SH_W-1:0]  share_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [UNIT_W-1:0]       unit_t;

  typedef enum logic [2:0] {
    IDLE, SUM, DECIDE, MULDIV, REMC, SHINIT, SCAN, DONE
  } state_t;

  function automatic share_t mul_small(input count_t c, input unit_t m);
    logic [SH_W-1:0] a;
    logic [SH_W-1:0] p;
    a = SH_W'(c);
    p = (m[0] ? a : '0) + (m[1] ? (a << 1) : '0) + (m[2] ? (a << 2) : '0);
    return share_t'(p);
  endfunction

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;
  count_t              target_r, target_nxt;
  logic                skip_r, skip_nxt;

  count_t              cnt_r   [NC];
  count_t              cnt_nxt [NC];
  count_t              res_r   [NC];
  count_t              res_nxt [NC];
  share_t              share_r   [NC];
  share_t              share_nxt [NC];
  idx_t                rank_r   [NC];
  idx_t                rank_nxt [NC];
  idx_t                rank_c   [NC];
  idx_t                ord_r   [NC];
  idx_t                ord_nxt [NC];
  count_t              in_cnt  [NC];

  total_t              total_r, total_nxt;
  count_t              newsum_r, newsum_nxt;
  logic [2*CB-1:0]     acc_r, acc_nxt;
  count_t              mc_r, mc_nxt;
  total_t              dr_r, dr_nxt;
  count_t              dd_r, dd_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [PH_W-1:0]     phase_r, phase_nxt;
  idx_t                scan_r, scan_nxt;
  share_t              best_r, best_nxt;
  idx_t                bk_r, bk_nxt;
  unit_t               units_r, units_nxt;

  logic [2*CB-1:0]     acc_step;
  logic [TOT_W:0]      trial;
  logic [TOT_W:0]      trial_diff;
  logic                q_bit;
  total_t              dr_step;
  count_t              dd_step;
  idx_t                mc_idx;
  share_t              scan_v;
  share_t              total_s;
  logic                scan_gt;
  logic                scan_hit;
  logic                scan_last;
  share_t              scan_best;
  idx_t                scan_bk;
  count_t              left_c;
  unit_t               rem_c;

  assign in_cnt[0] = in_data.count_a;
  assign in_cnt[1] = in_data.count_c;
  assign in_cnt[2] = in_data.count_g;
  assign in_cnt[3] = in_data.count_t;
  assign in_cnt[4] = in_data.count_n;
  assign in_cnt[5] = in_data.count_del;

  assign busy      = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // bit-serial multiply, msb first, and one restoring divide step
  assign acc_step   = {acc_r[2*CB-2:0], 1'b0} +
                      (mc_r[CB-1] ? {{CB{1'b0}}, target_r} : '0);
  assign trial      = {dr_r, dd_r[CB-1]};
  assign trial_diff = trial - {1'b0, total_r};
  assign q_bit      = (trial >= {1'b0, total_r});
  assign dr_step    = q_bit ? trial_diff[TOT_W-1:0] : trial[TOT_W-1:0];
  assign dd_step    = {dd_r[CB-2:0], q_bit};
  assign mc_idx     = (phase_r < PH_W'(NC - 1)) ? idx_t'(phase_r + PH_W'(1)) : '0;

  // leftover scan over the sorted shares
  assign scan_v    = share_r[scan_r];
  assign total_s   = share_t'(SH_W'(total_r));
  assign scan_gt   = (scan_v > best_r);
  assign scan_best = scan_gt ? scan_v : best_r;
  assign scan_bk   = scan_gt ? scan_r : bk_r;
  assign scan_hit  = (scan_v >= total_s);
  assign scan_last = scan_hit || (scan_r == idx_t'(NC - 1));

  assign left_c = target_r - newsum_r;
  assign rem_c  = (target_r <= newsum_r)          ? '0 :
                  (left_c > count_t'(MAX_REM))    ? unit_t'(MAX_REM) :
                                                    left_c[UNIT_W-1:0];

  // stable descending rank of each count
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      rank_c[i] = '0;
      for (int j = 0; j < NC; j++) begin
        if (j != i) begin
          if ((cnt_r[j] > cnt_r[i]) || ((cnt_r[j] == cnt_r[i]) && (j < i))) begin
            rank_c[i] = rank_c[i] + idx_t'(1);
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    target_nxt    = target_r;
    skip_nxt      = skip_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    share_nxt     = share_r;
    rank_nxt      = rank_r;
    ord_nxt       = ord_r;
    total_nxt     = total_r;
    newsum_nxt    = newsum_r;
    acc_nxt       = acc_r;
    mc_nxt        = mc_r;
    dr_nxt        = dr_r;
    dd_nxt        = dd_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    scan_nxt      = scan_r;
    best_nxt      = best_r;
    bk_nxt        = bk_r;
    units_nxt     = units_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEPTH_GOAL: begin
          target_nxt = cfg_wdata[CB-1:0];
        end
        REG_SKIP_WHEN_BELOW: begin
          skip_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      IDLE: begin
        if (start) begin
          cnt_nxt   = in_cnt;
          state_nxt = SUM;
        end
      end

      SUM: begin
        total_nxt = TOT_W'(cnt_r[0]) + TOT_W'(cnt_r[1]) + TOT_W'(cnt_r[2]) +
                    TOT_W'(cnt_r[3]) + TOT_W'(cnt_r[4]) + TOT_W'(cnt_r[5]);
        state_nxt = DECIDE;
      end

      DECIDE: begin
        out_data_nxt.scaled_a         = cnt_r[0];
        out_data_nxt.scaled_c         = cnt_r[1];
        out_data_nxt.scaled_g         = cnt_r[2];
        out_data_nxt.scaled_t         = cnt_r[3];
        out_data_nxt.scaled_n         = cnt_r[4];
        out_data_nxt.scaled_del       = cnt_r[5];
        out_data_nxt.passed_through   = 1'b0;
        out_data_nxt.zero_total_error = 1'b0;
        rank_nxt   = rank_c;
        newsum_nxt = '0;
        acc_nxt    = '0;
        mc_nxt     = cnt_r[0];
        step_nxt   = '0;
        phase_nxt  = '0;
        if (skip_r && (total_r <= TOT_W'(target_r))) begin
          out_data_nxt.passed_through = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end else if (total_r == '0) begin
          out_data_nxt.zero_total_error = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end else begin
          state_nxt = MULDIV;
        end
      end

      MULDIV: begin
        acc_nxt  = acc_step;
        mc_nxt   = {mc_r[CB-2:0], 1'b0};
        dr_nxt   = dr_step;
        dd_nxt   = dd_step;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(CB - 1)) begin
          step_nxt = '0;
          acc_nxt  = '0;
          mc_nxt   = cnt_r[mc_idx];
          dr_nxt   = TOT_W'(acc_step[2*CB-1:CB]);
          dd_nxt   = acc_step[CB-1:0];
          for (int i = 0; i < NC; i++) begin
            if (phase_r == PH_W'(i + 1)) begin
              res_nxt[i] = dd_step;
            end
          end
          if (phase_r != '0) begin
            newsum_nxt = newsum_r + dd_step;
          end
          if (phase_r == PH_W'(NC)) begin
            state_nxt = REMC;
          end else begin
            phase_nxt = phase_r + PH_W'(1);
          end
        end
      end

      REMC: begin
        units_nxt = rem_c;
        state_nxt = (rem_c == '0) ? DONE : SHINIT;
      end

      SHINIT: begin
        for (int p = 0; p < NC; p++) begin
          for (int i = 0; i < NC; i++) begin
            if (rank_r[i] == idx_t'(p)) begin
              share_nxt[p] = mul_small(cnt_r[i], units_r);
              ord_nxt[p]   = idx_t'(i);
            end
          end
        end
        scan_nxt  = '0;
        best_nxt  = '0;
        bk_nxt    = '0;
        state_nxt = SCAN;
      end

      SCAN: begin
        if (scan_last) begin
          for (int p = 0; p < NC; p++) begin
            if (scan_bk == idx_t'(p)) begin
              share_nxt[p] = share_r[p] - total_s;
            end
          end
          for (int i = 0; i < NC; i++) begin
            if (ord_r[scan_bk] == idx_t'(i)) begin
              res_nxt[i] = res_r[i] + count_t'(1);
            end
          end
          units_nxt = units_r - unit_t'(1);
          scan_nxt  = '0;
          best_nxt  = '0;
          bk_nxt    = '0;
          if (units_r == unit_t'(1)) begin
            state_nxt = DONE;
          end
        end else begin
          scan_nxt = scan_r + idx_t'(1);
          best_nxt = scan_best;
          bk_nxt   = scan_bk;
        end
      end

      DONE: begin
        out_data_nxt.scaled_a         = res_r[0];
        out_data_nxt.scaled_c         = res_r[1];
        out_data_nxt.scaled_g         = res_r[2];
        out_data_nxt.scaled_t         = res_r[3];
        out_data_nxt.scaled_n         = res_r[4];
        out_data_nxt.scaled_del       = res_r[5];
        out_data_nxt.passed_through   = 1'b0;
        out_data_nxt.zero_total_error = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = IDLE;
      end

      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      target_r    <= '0;
      skip_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      target_r    <= target_nxt;
      skip_r      <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
    share_r  <= share_nxt;
    rank_r   <= rank_nxt;
    ord_r    <= ord_nxt;
    total_r  <= total_nxt;
    newsum_r <= newsum_nxt;
    acc_r    <= acc_nxt;
    mc_r     <= mc_nxt;
    dr_r     <= dr_nxt;
    dd_r     <= dd_nxt;
    step_r   <= step_nxt;
    phase_r  <= phase_nxt;
    scan_r   <= scan_nxt;
    best_r   <= best_nxt;
    bk_r     <= bk_nxt;
    units_r  <= units_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/cvr_checker.sv -----
// port-level checker for the count vector rescaler, bound to the top level
`default_nettype none

`include "count_vector_rescaler_defines.svh"

module cvr_checker import cvr_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire out_t out_data
);

  // accepted transaction keeps the block busy
  `CVR_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
  // no result in the cycle right after acceptance
  `CVR_ASSERT_NXT(a_no_result_after_accept, start && !busy, !out_valid)
  // result strobe lasts one cycle
  `CVR_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  // block is free again while its result is shown
  `CVR_ASSERT_IMP(a_idle_on_result, out_valid, !busy)
  // pass-through and zero-total error never both flagged
  `CVR_ASSERT_IMP(a_flags_exclusive, out_valid,
                  !(out_data.passed_through && out_data.zero_total_error))

endmodule

bind count_vector_rescaler cvr_checker u_cvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

// ----- tb/count_rescale_checker.sv -----
// checker for the count vector rescaler: watches all channels, predicts and compares results
module count_rescale_checker import cvr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  in_t                      in_data,
  input  logic                     out_valid,
  input  out_t                     out_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output int unsigned              mismatches,
  output int unsigned              outstanding
);

  count_t      depth_reg;
  logic        skip_reg;
  out_t        pending_scaled [$];
  out_t        want;
  int unsigned errors_seen = 0;

  assign mismatches = errors_seen;

  function automatic out_t predict_scaled(input in_t v, input count_t depth, input logic skip);
    count_t cnt [NUM_COUNTS];
    longint scaled [NUM_COUNTS];
    longint share [NUM_COUNTS];
    int     order [NUM_COUNTS];
    longint sum;
    longint floors;
    longint left;
    longint best;
    int     rank;
    int     pick;
    int     j;
    logic   found;
    out_t   r;
    cnt = '{v.count_a, v.count_c, v.count_g, v.count_t, v.count_n, v.count_del};
    sum = 0;
    floors = 0;
    for (int i = 0; i < NUM_COUNTS; i++) begin
      sum += longint'(cnt[i]);
      scaled[i] = longint'(cnt[i]);
    end
    r = '0;
    if (skip && sum <= longint'(depth)) begin
      r.passed_through = 1'b1;
    end else if (sum == 0) begin
      r.zero_total_error = 1'b1;
    end else begin
      for (int i = 0; i < NUM_COUNTS; i++) begin
        scaled[i] = (longint'(cnt[i]) * longint'(depth)) / sum;
        floors += scaled[i];
      end
      left = (longint'(depth) > floors) ? longint'(depth) - floors : 0;
      if (left > 5) left = 5;
      // stable descending order: rank is the number of counts placed ahead
      for (int i = 0; i < NUM_COUNTS; i++) begin
        rank = 0;
        for (int k = 0; k < NUM_COUNTS; k++) begin
          if (cnt[k] > cnt[i] || (cnt[k] == cnt[i] && k < i)) rank++;
        end
        order[rank] = i;
        share[i] = longint'(cnt[i]) * left;
      end
      for (longint u = 0; u < left; u++) begin
        best = 0;
        pick = 0;
        j = 0;
        found = 1'b0;
        while (j < NUM_COUNTS && !found) begin
          if (share[order[j]] > best) begin
            best = share[order[j]];
            pick = j;
          end
          if (share[order[j]] >= sum) found = 1'b1;
          j++;
        end
        share[order[pick]] -= sum;
        scaled[order[pick]] += 1;
      end
    end
    r.scaled_a   = count_t'(scaled[0]);
    r.scaled_c   = count_t'(scaled[1]);
    r.scaled_g   = count_t'(scaled[2]);
    r.scaled_t   = count_t'(scaled[3]);
    r.scaled_n   = count_t'(scaled[4]);
    r.scaled_del = count_t'(scaled[5]);
    return r;
  endfunction

  task automatic check_field(input string field, input longint unsigned exp_val,
                             input longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
      errors_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      depth_reg = '0;
      skip_reg = 1'b1;
      pending_scaled.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEPTH_GOAL:      depth_reg = count_t'(cfg_wdata);
          REG_SKIP_WHEN_BELOW: skip_reg = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (pending_scaled.size() == 0) begin
          $error("result transaction with no item outstanding");
          errors_seen++;
        end else begin
          want = pending_scaled.pop_front();
          check_field("scaled_a", want.scaled_a, out_data.scaled_a);
          check_field("scaled_c", want.scaled_c, out_data.scaled_c);
          check_field("scaled_g", want.scaled_g, out_data.scaled_g);
          check_field("scaled_t", want.scaled_t, out_data.scaled_t);
          check_field("scaled_n", want.scaled_n, out_data.scaled_n);
          check_field("scaled_del", want.scaled_del, out_data.scaled_del);
          check_field("passed_through", want.passed_through, out_data.passed_through);
          check_field("zero_total_error", want.zero_total_error, out_data.zero_total_error);
        end
      end
      if (start && !busy) begin
        pending_scaled.push_back(predict_scaled(in_data, depth_reg, skip_reg));
      end
    end
    outstanding <= pending_scaled.size();
  end

endmodule

// ----- tb/count_vector_rescaler_test.sv -----
// top of the rescaler testbench: clock, reset, stimulus, watchdog and verdict
module count_vector_rescaler_test;
  import cvr_pkg::*;

  typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;
  typedef enum int {SPREAD_TINY, SPREAD_MID, SPREAD_FULL, SPREAD_MIXED} spread_e;

  localparam cfg_idx_t REG_SPARE_2 = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPARE_3 = cfg_idx_t'(3);
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 200;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = REG_DEPTH_GOAL;
  cfg_word_t   cfg_wdata = '0;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned idle_pct = 0;
  int unsigned stall = 0;
  int unsigned idle_plan [4] = '{0, 46, 0, 25};

  always #2 clk = ~clk;

  count_vector_rescaler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  count_rescale_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic in_t pack_counts(input count_t ca, cc, cg, ct, cn, cd);
    in_t v;
    v.count_a = ca;
    v.count_c = cc;
    v.count_g = cg;
    v.count_t = ct;
    v.count_n = cn;
    v.count_del = cd;
    return v;
  endfunction

  function automatic in_t random_counts();
    spread_e spread;
    count_t  v [NUM_COUNTS];
    spread = spread_e'($urandom_range(0, 3));
    for (int i = 0; i < NUM_COUNTS; i++) begin
      case (spread)
        SPREAD_TINY: v[i] = count_t'($urandom_range(0, 7));
        SPREAD_MID:  v[i] = count_t'($urandom_range(0, 4095));
        SPREAD_FULL: v[i] = count_t'($urandom);
        default: begin
          case ($urandom_range(0, 3))
            0:       v[i] = '0;
            1:       v[i] = '1;
            2:       v[i] = count_t'($urandom_range(0, 3));
            default: v[i] = count_t'($urandom);
          endcase
        end
      endcase
    end
    if ($urandom_range(0, 39) == 0) v = '{default: '0};
    return pack_counts(v[0], v[1], v[2], v[3], v[4], v[5]);
  endfunction

  // start stays high after acceptance so the next transaction can follow back to back
  task automatic send_counts(input in_t v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic write_pair(input cfg_idx_t idx0, input cfg_word_t val0,
                            input cfg_idx_t idx1, input cfg_word_t val1);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx0;
    cfg_wdata <= val0;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= idx1;
    cfg_wdata <= val1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall = 0;
      else stall++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero depth with skip on
    send_counts(pack_counts(0, 0, 0, 0, 0, 0));
    send_counts(pack_counts(1, 0, 0, 0, 0, 0));
    write_pair(REG_DEPTH_GOAL, '0, REG_SKIP_WHEN_BELOW, cfg_word_t'(20'hFFFFE));
    send_counts(pack_counts(0, 0, 0, 0, 0, 0));
    send_counts(pack_counts('1, '1, '1, '1, '1, '1));
    write_pair(REG_DEPTH_GOAL, '1, REG_SKIP_WHEN_BELOW, '0);
    send_counts(pack_counts('1, '1, '1, '1, '1, '1));
    send_counts(pack_counts(1, 1, 1, 1, 1, 1));
    send_counts(pack_counts(5, 3, 3, 0, 1, 0));
    write_pair(REG_DEPTH_GOAL, '1, REG_SKIP_WHEN_BELOW, cfg_word_t'(1));
    send_counts(pack_counts(1, 2, 3, 4, 5, 6));
    send_counts(pack_counts('1, 0, 0, 0, 0, 0));
    send_counts(pack_counts('1, 1, 0, 0, 0, 0));
    // writes to unused indexes must leave both registers alone
    write_pair(REG_SPARE_2, '0, REG_SPARE_3, '0);
    send_counts(pack_counts(7, 7, 7, 7, 7, 7));
    write_pair(REG_DEPTH_GOAL, cfg_word_t'(10), REG_SKIP_WHEN_BELOW, '0);
    send_counts(pack_counts(1, 1, 1, 1, 1, 1));
    send_counts(pack_counts(3, 1, 1, 1, 1, 0));
    send_counts(pack_counts(2, 2, 1, 1, 0, 0));
    send_counts(pack_counts(0, 0, 0, 0, 0, 9));
    send_counts(pack_counts(0, 1, 0, 2, 0, 1));
    write_pair(REG_DEPTH_GOAL, cfg_word_t'(7), REG_SKIP_WHEN_BELOW, '0);
    send_counts(pack_counts(1, 1, 1, 1, 1, 1));
    send_counts(pack_counts(4, 2, 2, 1, 1, 0));
    send_counts(pack_counts(3, 3, 3, 3, 3, 4));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_pair(REG_DEPTH_GOAL, '1, REG_SKIP_WHEN_BELOW, {19'($urandom), 1'b0});
        1: write_pair(REG_DEPTH_GOAL, '0, REG_SKIP_WHEN_BELOW, '0);
        2: write_pair(REG_DEPTH_GOAL, cfg_word_t'($urandom_range(1, 200)),
                      REG_SKIP_WHEN_BELOW, '0);
        3: write_pair(REG_DEPTH_GOAL, '1, REG_SKIP_WHEN_BELOW, {19'($urandom), 1'b1});
        4: write_pair(REG_DEPTH_GOAL, cfg_word_t'($urandom),
                      REG_SKIP_WHEN_BELOW, cfg_word_t'($urandom));
        5: write_pair(REG_DEPTH_GOAL, cfg_word_t'(1), REG_SKIP_WHEN_BELOW, '0);
        6: write_pair(REG_DEPTH_GOAL, cfg_word_t'($urandom_range(0, 5000)),
                      REG_SKIP_WHEN_BELOW, cfg_word_t'(1));
        default: write_pair(REG_DEPTH_GOAL, cfg_word_t'($urandom),
                            REG_SKIP_WHEN_BELOW, '0);
      endcase
      idle_pct = idle_plan[phase % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_counts(random_counts());
        if ($urandom_range(0, 49) == 0) settle();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
